// ===== src/pcc_pkg.sv =====
// shared types, command codes, status bytes and store map of the pin card command processor
package pcc_pkg;

  localparam int STORE_DEPTH_DEF = 2048;
  localparam int LAST_CHUNK_DEF  = 30;
  localparam int NV_AW_MAX       = 12;

  // instruction bytes
  localparam logic [7:0] INS_READ_ID    = 8'h01;
  localparam logic [7:0] INS_READ_VER   = 8'h02;
  localparam logic [7:0] INS_WR_PIN_PUK = 8'h03;
  localparam logic [7:0] INS_VFY_PIN    = 8'h06;
  localparam logic [7:0] INS_VFY_PUK    = 8'h07;
  localparam logic [7:0] INS_ASSIGN     = 8'h08;
  localparam logic [7:0] INS_WR_PIN     = 8'h09;
  localparam logic [7:0] INS_KEY_CHUNK  = 8'h0A;
  localparam logic [7:0] INS_CHALLENGE  = 8'h0C;
  localparam logic [7:0] INS_ATTEMPTS   = 8'h0D;
  localparam logic [7:0] INS_PIN_DEF    = 8'h0E;

  // expected lengths
  localparam logic [7:0] LEN_ID       = 8'd24;
  localparam logic [7:0] LEN_ONE      = 8'd1;
  localparam logic [7:0] LEN_TWO      = 8'd2;
  localparam logic [7:0] LEN_PIN      = 8'd4;
  localparam logic [7:0] LEN_PIN_PUK  = 8'd8;
  localparam logic [7:0] LEN_ASSIGN   = 8'd28;
  localparam logic [7:0] LEN_CHAL     = 8'd32;
  localparam logic [7:0] LEN_CHUNK_MX = 8'd65;

  // status bytes
  localparam logic [7:0] SW_OK1        = 8'h90;
  localparam logic [7:0] SW_ZERO       = 8'h00;
  localparam logic [7:0] SW_WRONG_LEN  = 8'h6C;
  localparam logic [7:0] SW_BAD_CLA    = 8'h6E;
  localparam logic [7:0] SW_BAD_INS    = 8'h6D;
  localparam logic [7:0] SW_COND       = 8'h69;
  localparam logic [7:0] SW_NOT_VER    = 8'h82;
  localparam logic [7:0] SW_PIN_LOCK   = 8'h83;
  localparam logic [7:0] SW_PUK_LOCK   = 8'h84;
  localparam logic [7:0] SW_WRONG_DATA = 8'h6A;
  localparam logic [7:0] SW_ASSIGNED   = 8'h81;
  localparam logic [7:0] SW_BAD_PARAM  = 8'h84;
  localparam logic [7:0] SW_RETRY      = 8'h63;
  localparam logic [7:0] RETRY_BASE    = 8'hC0;
  localparam logic [7:0] ERASED        = 8'hFF;

  // store map
  localparam logic [NV_AW_MAX-1:0] A_PIN       = 12'd0;
  localparam logic [NV_AW_MAX-1:0] A_ID        = 12'd4;
  localparam logic [NV_AW_MAX-1:0] A_FLAG      = 12'd28;
  localparam logic [NV_AW_MAX-1:0] A_PIN_TRIES = 12'd29;
  localparam logic [NV_AW_MAX-1:0] A_PUK_TRIES = 12'd30;
  localparam logic [NV_AW_MAX-1:0] A_PUK       = 12'd31;
  localparam logic [NV_AW_MAX-1:0] A_KSIZE     = 12'd35;
  localparam logic [NV_AW_MAX-1:0] A_KDATA     = 12'd37;

  // configuration register indexes
  localparam logic [1:0] CFG_MAX_PIN = 2'd0;
  localparam logic [1:0] CFG_MAX_PUK = 2'd1;
  localparam logic [1:0] CFG_VERSION = 2'd2;
  localparam logic [1:0] CFG_CLASS   = 2'd3;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_HDR, ST_CHK, ST_INS, ST_STRM_RD, ST_STRM_TX, ST_BYTE,
    ST_PD_RD, ST_PD_CHK, ST_DATA, ST_DCMP, ST_DEND, ST_WSEQ, ST_SW1, ST_SW2
  } state_t;

  typedef enum logic [2:0] {
    W_RESTORE, W_ASSIGN, W_PUK_OK, W_KSIZE, W_PIN_TRY, W_FAIL
  } wseq_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } tx_beat_t;

  typedef struct packed {
    logic [3:0] max_pin;
    logic [3:0] max_puk;
    logic [7:0] version;
    logic [7:0] cla;
  } cfg_t;

  function automatic logic has_data(input logic [7:0] ins);
    logic r;
    case (ins)
      INS_WR_PIN_PUK, INS_VFY_PIN, INS_VFY_PUK, INS_ASSIGN,
      INS_WR_PIN, INS_KEY_CHUNK, INS_CHALLENGE: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/pcc_ram.sv =====
// generic single-clock ram with one write port and a registered read port
module pcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== src/pcc_seq.sv =====
// command sequencer: header decode, data absorb and read-modify-write of the store
module pcc_seq #(
  parameter int STORE_DEPTH = 2048,
  parameter int LAST_CHUNK  = 30
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pcc_pkg::cfg_t                  cfg,
  input  logic                           rx_valid,
  input  logic [7:0]                     rx_byte,
  output logic                           rx_ready,
  input  logic                           can_send,
  output pcc_pkg::tx_beat_t              tx,
  output logic                           nv_we,
  output logic [$clog2(STORE_DEPTH)-1:0] nv_waddr,
  output logic [7:0]                     nv_wdata,
  output logic                           nv_re,
  output logic [$clog2(STORE_DEPTH)-1:0] nv_raddr,
  input  logic [7:0]                     nv_rdata
);
  import pcc_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam logic [AW-1:0] CLR_END = AW'(STORE_DEPTH - 1);
  localparam logic [7:0] LAST_CHUNK_B = 8'(LAST_CHUNK);

  state_t state_r, state_nxt;
  wseq_t  wkind_r, wkind_nxt;
  logic [2:0] phase_r, phase_nxt, widx_r, widx_nxt;
  logic [7:0] cla_r, cla_nxt, ins_r, ins_nxt, len_r, len_nxt, cnt_r, cnt_nxt;
  logic [7:0] tries_r, tries_nxt, chunk_r, chunk_nxt, byte_r, byte_nxt;
  logic [7:0] sw1_r, sw1_nxt, sw2_r, sw2_nxt;
  logic       ok_r, ok_nxt, pin_ok_r, pin_ok_nxt, mask_r, mask_nxt;
  logic       erased_r, erased_nxt;
  logic [7:0] newpin_r [4];
  logic [7:0] newpin_nxt [4];
  logic [NV_AW_MAX-1:0] ptr_r, ptr_nxt, wa, ra;
  logic [4:0] left_r, left_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [7:0] tfail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      phase_r  <= '0;
      cla_r    <= '0;
      ins_r    <= '0;
      len_r    <= '0;
      cnt_r    <= '0;
      tries_r  <= '0;
      chunk_r  <= '0;
      ok_r     <= 1'b1;
      pin_ok_r <= 1'b0;
      clr_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      cla_r    <= cla_nxt;
      ins_r    <= ins_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      tries_r  <= tries_nxt;
      chunk_r  <= chunk_nxt;
      ok_r     <= ok_nxt;
      pin_ok_r <= pin_ok_nxt;
      clr_r    <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wkind_r  <= wkind_nxt;
    widx_r   <= widx_nxt;
    byte_r   <= byte_nxt;
    sw1_r    <= sw1_nxt;
    sw2_r    <= sw2_nxt;
    mask_r   <= mask_nxt;
    erased_r <= erased_nxt;
    ptr_r    <= ptr_nxt;
    left_r   <= left_nxt;
    newpin_r <= newpin_nxt;
  end

  assign rx_ready = (state_r == ST_IDLE);
  assign tfail    = tries_r - 8'd1;

  always_comb begin
    state_nxt  = state_r;
    wkind_nxt  = wkind_r;
    phase_nxt  = phase_r;
    widx_nxt   = widx_r;
    cla_nxt    = cla_r;
    ins_nxt    = ins_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    tries_nxt  = tries_r;
    chunk_nxt  = chunk_r;
    byte_nxt   = byte_r;
    sw1_nxt    = sw1_r;
    sw2_nxt    = sw2_r;
    ok_nxt     = ok_r;
    pin_ok_nxt = pin_ok_r;
    mask_nxt   = mask_r;
    erased_nxt = erased_r;
    newpin_nxt = newpin_r;
    ptr_nxt    = ptr_r;
    left_nxt   = left_r;
    clr_nxt    = clr_r;
    tx         = '0;
    nv_we      = 1'b0;
    nv_re      = 1'b0;
    nv_wdata   = ERASED;
    wa         = '0;
    ra         = '0;

    case (state_r)
      ST_CLEAR: begin
        nv_we   = 1'b1;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == CLR_END) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (rx_valid) begin
          case (phase_r)
            3'd1: begin
              ins_nxt   = rx_byte;
              phase_nxt = 3'd2;
            end
            3'd2: phase_nxt = 3'd3;
            3'd3: phase_nxt = 3'd4;
            3'd4: begin
              len_nxt   = rx_byte;
              state_nxt = ST_HDR;
            end
            3'd5: begin
              byte_nxt  = rx_byte;
              state_nxt = ST_DATA;
            end
            default: begin
              cla_nxt   = rx_byte;
              phase_nxt = 3'd1;
            end
          endcase
        end
      end

      ST_HDR: begin
        cnt_nxt   = '0;
        ok_nxt    = 1'b1;
        phase_nxt = '0;
        state_nxt = ST_SW1;
        sw1_nxt   = SW_WRONG_LEN;
        if (cla_r != cfg.cla) begin
          sw1_nxt = SW_BAD_CLA;
          sw2_nxt = SW_ZERO;
        end else begin
          case (ins_r)
            INS_READ_ID: begin
              sw2_nxt = LEN_ID;
              if (len_r == LEN_ID) begin
                nv_re = 1'b1; ra = A_FLAG; state_nxt = ST_CHK;
              end
            end
            INS_READ_VER, INS_PIN_DEF: begin
              sw2_nxt = LEN_ONE;
              if (len_r == LEN_ONE) state_nxt = ST_INS;
            end
            INS_ATTEMPTS: begin
              sw2_nxt = LEN_TWO;
              if (len_r == LEN_TWO) state_nxt = ST_INS;
            end
            INS_WR_PIN_PUK: begin
              sw2_nxt = LEN_PIN_PUK;
              if (len_r == LEN_PIN_PUK) state_nxt = ST_INS;
            end
            INS_WR_PIN: begin
              sw2_nxt = LEN_PIN;
              if (len_r == LEN_PIN) state_nxt = ST_INS;
            end
            INS_VFY_PIN: begin
              sw2_nxt = LEN_PIN;
              if (len_r == LEN_PIN) begin
                nv_re = 1'b1; ra = A_PIN_TRIES; state_nxt = ST_CHK;
              end
            end
            INS_VFY_PUK: begin
              sw2_nxt = LEN_PIN_PUK;
              if (len_r == LEN_PIN_PUK) begin
                nv_re = 1'b1; ra = A_PUK_TRIES; state_nxt = ST_CHK;
              end
            end
            INS_ASSIGN: begin
              sw2_nxt = LEN_ASSIGN;
              if (len_r == LEN_ASSIGN) begin
                nv_re = 1'b1; ra = A_FLAG; state_nxt = ST_CHK;
              end
            end
            INS_KEY_CHUNK: begin
              sw2_nxt = LEN_CHUNK_MX;
              if (len_r != 8'd0 && len_r <= LEN_CHUNK_MX) state_nxt = ST_INS;
            end
            INS_CHALLENGE: begin
              if (!pin_ok_r) begin
                sw1_nxt = SW_COND;
                sw2_nxt = SW_NOT_VER;
              end else begin
                sw2_nxt = LEN_CHAL;
                if (len_r == LEN_CHAL) state_nxt = ST_INS;
              end
            end
            default: begin
              sw1_nxt = SW_BAD_INS;
              sw2_nxt = SW_ZERO;
            end
          endcase
        end
      end

      ST_CHK: begin
        state_nxt = ST_INS;
        case (ins_r)
          INS_VFY_PIN, INS_VFY_PUK: begin
            tries_nxt = nv_rdata;
            if (nv_rdata == 8'd0) begin
              sw1_nxt   = SW_COND;
              sw2_nxt   = (ins_r == INS_VFY_PIN) ? SW_PIN_LOCK : SW_PUK_LOCK;
              state_nxt = ST_SW1;
            end
          end
          INS_ASSIGN: begin
            if (nv_rdata != ERASED) begin
              sw1_nxt   = SW_WRONG_DATA;
              sw2_nxt   = SW_ASSIGNED;
              state_nxt = ST_SW1;
            end
          end
          default: mask_nxt = (nv_rdata != ERASED);
        endcase
      end

      ST_INS: begin
        if (can_send) begin
          tx = '{valid: 1'b1, data: ins_r, last: has_data(ins_r)};
          sw1_nxt = SW_OK1;
          sw2_nxt = SW_ZERO;
          if (has_data(ins_r)) begin
            phase_nxt = 3'd5;
            state_nxt = ST_IDLE;
          end else begin
            case (ins_r)
              INS_READ_ID: begin
                ptr_nxt = A_ID; left_nxt = 5'd24; state_nxt = ST_STRM_RD;
              end
              INS_ATTEMPTS: begin
                ptr_nxt = A_PIN_TRIES; left_nxt = 5'd2; mask_nxt = 1'b1;
                state_nxt = ST_STRM_RD;
              end
              INS_PIN_DEF: begin
                left_nxt = '0; erased_nxt = 1'b1; state_nxt = ST_PD_RD;
              end
              default: begin
                byte_nxt = cfg.version; state_nxt = ST_BYTE;
              end
            endcase
          end
        end
      end

      ST_STRM_RD: begin
        nv_re = 1'b1;
        ra    = ptr_r;
        state_nxt = ST_STRM_TX;
      end

      ST_STRM_TX: begin
        if (can_send) begin
          tx = '{valid: 1'b1, data: (mask_r ? nv_rdata : 8'd0), last: 1'b0};
          ptr_nxt  = ptr_r + 12'd1;
          left_nxt = left_r - 5'd1;
          state_nxt = (left_r == 5'd1) ? ST_SW1 : ST_STRM_RD;
        end
      end

      ST_PD_RD: begin
        nv_re = 1'b1;
        ra    = A_PIN + {7'd0, left_r};
        state_nxt = ST_PD_CHK;
      end

      ST_PD_CHK: begin
        erased_nxt = erased_r & (nv_rdata == ERASED);
        left_nxt   = left_r + 5'd1;
        state_nxt  = ST_PD_RD;
        if (left_r == 5'd3) begin
          byte_nxt  = (erased_r && nv_rdata == ERASED) ? 8'd0 : 8'd1;
          state_nxt = ST_BYTE;
        end
      end

      ST_BYTE: begin
        if (can_send) begin
          tx = '{valid: 1'b1, data: byte_r, last: 1'b0};
          state_nxt = ST_SW1;
        end
      end

      ST_DATA: begin
        cnt_nxt   = cnt_r + 8'd1;
        state_nxt = ST_DEND;
        nv_wdata  = byte_r;
        case (ins_r)
          INS_WR_PIN_PUK: begin
            nv_we = 1'b1;
            wa = (cnt_r < 8'd4) ? A_PIN + {4'd0, cnt_r} : A_PUK + {4'd0, cnt_r} - 12'd4;
          end
          INS_VFY_PIN: begin
            nv_re = 1'b1;
            ra = A_PIN + {10'd0, cnt_r[1:0]};
            state_nxt = ST_DCMP;
          end
          INS_VFY_PUK: begin
            if (cnt_r < 8'd4) begin
              nv_re = 1'b1;
              ra = A_PUK + {4'd0, cnt_r};
              state_nxt = ST_DCMP;
            end else begin
              newpin_nxt[cnt_r[1:0]] = byte_r;
            end
          end
          INS_ASSIGN: begin
            nv_we = 1'b1;
            wa = (cnt_r < LEN_ID) ? A_ID + {4'd0, cnt_r}
                                  : A_PUK + {4'd0, cnt_r} - {4'd0, LEN_ID};
          end
          INS_WR_PIN: begin
            nv_we = 1'b1;
            wa = A_PIN + {10'd0, cnt_r[1:0]};
          end
          INS_KEY_CHUNK: begin
            if (cnt_r == 8'd0) begin
              chunk_nxt = byte_r;
            end else if (chunk_r <= LAST_CHUNK_B) begin
              nv_we = 1'b1;
              wa = A_KDATA + {chunk_r[5:0], 6'd0} + {4'd0, cnt_r} - 12'd1;
            end
          end
          INS_CHALLENGE: ;
          default: begin
            phase_nxt = '0;
            state_nxt = ST_IDLE;
          end
        endcase
      end

      ST_DCMP: begin
        if (byte_r != nv_rdata) ok_nxt = 1'b0;
        state_nxt = ST_DEND;
      end

      ST_DEND: begin
        state_nxt = ST_IDLE;
        if (cnt_r >= len_r) begin
          phase_nxt = '0;
          widx_nxt  = '0;
          sw1_nxt   = SW_OK1;
          sw2_nxt   = SW_ZERO;
          state_nxt = ST_WSEQ;
          case (ins_r)
            INS_VFY_PIN, INS_VFY_PUK: begin
              if (ok_r) begin
                pin_ok_nxt = 1'b1;
                wkind_nxt  = (ins_r == INS_VFY_PUK) ? W_PUK_OK : W_PIN_TRY;
              end else begin
                wkind_nxt = W_FAIL;
                ptr_nxt   = (ins_r == INS_VFY_PIN) ? A_PIN_TRIES : A_PUK_TRIES;
                sw1_nxt   = SW_RETRY;
                sw2_nxt   = RETRY_BASE | tfail;
              end
            end
            INS_ASSIGN: wkind_nxt = W_ASSIGN;
            INS_WR_PIN_PUK, INS_WR_PIN: wkind_nxt = W_RESTORE;
            INS_KEY_CHUNK: begin
              wkind_nxt = W_KSIZE;
              if (chunk_r > LAST_CHUNK_B) begin
                sw1_nxt   = SW_WRONG_DATA;
                sw2_nxt   = SW_BAD_PARAM;
                state_nxt = ST_SW1;
              end else if (chunk_r != 8'd0) begin
                state_nxt = ST_SW1;
              end
            end
            default: state_nxt = ST_SW1;
          endcase
        end
      end

      ST_WSEQ: begin
        nv_we    = 1'b1;
        widx_nxt = widx_r + 3'd1;
        case (wkind_r)
          W_RESTORE, W_ASSIGN: begin
            case (widx_r)
              3'd0: begin wa = A_PIN_TRIES; nv_wdata = {4'd0, cfg.max_pin}; end
              3'd1: begin
                wa = A_PUK_TRIES; nv_wdata = {4'd0, cfg.max_puk};
                if (wkind_r == W_RESTORE) state_nxt = ST_SW1;
              end
              default: begin wa = A_FLAG; nv_wdata = 8'd0; state_nxt = ST_SW1; end
            endcase
          end
          W_PUK_OK: begin
            if (widx_r < 3'd4) begin
              wa = A_PIN + {9'd0, widx_r};
              nv_wdata = newpin_r[widx_r[1:0]];
            end else if (widx_r == 3'd4) begin
              wa = A_PIN_TRIES; nv_wdata = {4'd0, cfg.max_pin};
            end else begin
              wa = A_PUK_TRIES; nv_wdata = {4'd0, cfg.max_puk};
              state_nxt = ST_SW1;
            end
          end
          W_KSIZE: begin
            if (widx_r == 3'd0) begin
              wa = A_KSIZE; nv_wdata = 8'd0;
            end else begin
              wa = A_KSIZE + 12'd1; nv_wdata = len_r - 8'd1;
              state_nxt = ST_SW1;
            end
          end
          W_PIN_TRY: begin
            wa = A_PIN_TRIES; nv_wdata = {4'd0, cfg.max_pin};
            state_nxt = ST_SW1;
          end
          default: begin
            wa = ptr_r; nv_wdata = tfail;
            state_nxt = ST_SW1;
          end
        endcase
      end

      ST_SW1: begin
        if (can_send) begin
          tx = '{valid: 1'b1, data: sw1_r, last: 1'b0};
          state_nxt = ST_SW2;
        end
      end

      ST_SW2: begin
        if (can_send) begin
          tx = '{valid: 1'b1, data: sw2_r, last: 1'b1};
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign nv_waddr = (state_r == ST_CLEAR) ? clr_r : wa[AW-1:0];
  assign nv_raddr = ra[AW-1:0];
endmodule

// ===== src/pin_card_command_processor_top.sv =====
// top level of the pin card command processor
// Smart-card T=0 command handler for PIN and PUK management. The in_ channel
// carries received bytes, one per beat: a five-byte header (class, instruction,
// P1, P2, P3) followed by command data. The out_ channel returns the bytes to
// send: procedure byte, response data and two status bytes; out_tlast marks
// the final byte caused by one input beat. Header bytes 1..4 and non-final data
// bytes cause no output.
// Nonvolatile bytes live in one synchronous ram with a registered read; every
// access goes through the sequencer, one store access per cycle.
// Pin defined does four ram reads before its answer byte; read ID does one ram
// read and one send for each returned byte.
// in_tready is high only while the sequencer is idle, so one beat at a time.
// After reset the store is swept to 0xFF, one entry per cycle, over all
// STORE_DEPTH entries, with in_tready low; config writes are taken throughout.
// A stalled receiver holds the output register and the sequencer waits for it.
module pin_card_command_processor_top #(
  parameter int STORE_DEPTH = pcc_pkg::STORE_DEPTH_DEF,
  parameter int LAST_CHUNK  = pcc_pkg::LAST_CHUNK_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // rx_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // tx_byte
  output logic       out_tlast,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);
  import pcc_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);

  cfg_t       cfg_r;
  logic       out_tvalid_r;
  logic [7:0] out_tdata_r;
  logic       out_tlast_r;
  logic       can_send;
  tx_beat_t   tx;
  logic          nv_we, nv_re;
  logic [AW-1:0] nv_waddr, nv_raddr;
  logic [7:0]    nv_wdata, nv_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{max_pin: 4'd3, max_puk: 4'd3, version: 8'd200, cla: 8'd128};
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MAX_PIN: cfg_r.max_pin <= cfg_wdata[3:0];
        CFG_MAX_PUK: cfg_r.max_puk <= cfg_wdata[3:0];
        CFG_VERSION: cfg_r.version <= cfg_wdata;
        CFG_CLASS:   cfg_r.cla     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign can_send = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (tx.valid) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tx.valid) begin
      out_tdata_r <= tx.data;
      out_tlast_r <= tx.last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  pcc_seq #(.STORE_DEPTH(STORE_DEPTH), .LAST_CHUNK(LAST_CHUNK)) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .rx_valid (in_tvalid),
    .rx_byte  (in_tdata),
    .rx_ready (in_tready),
    .can_send (can_send),
    .tx       (tx),
    .nv_we    (nv_we),
    .nv_waddr (nv_waddr),
    .nv_wdata (nv_wdata),
    .nv_re    (nv_re),
    .nv_raddr (nv_raddr),
    .nv_rdata (nv_rdata)
  );

  pcc_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_nv (
    .clk   (clk),
    .we    (nv_we),
    .waddr (nv_waddr),
    .wdata (nv_wdata),
    .re    (nv_re),
    .raddr (nv_raddr),
    .rdata (nv_rdata)
  );
endmodule

// ===== src/pcc_chk.sv =====
// port checker for the pin card command processor, bound to the top level
module pcc_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);
  // a stalled beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat changed under stall");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // reset starts the store sweep, so no input is taken
  a_rst_busy: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input ready during store sweep");

  // when ready for input, any pending output closes a run
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && out_tvalid |-> out_tlast)
    else $error("input taken while a run is open");
endmodule

bind pin_card_command_processor_top pcc_chk u_chk (.*);
